// ===== design/pss_pkg.sv =====
// Shared types, constants, microprogram and action decode for the power supply sequencer.
package pss_pkg;

  // Field widths
  localparam int unsigned CmdW      = 2;
  localparam int unsigned EntryIdxW = 4;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FlagsW    = 3;
  localparam int unsigned ActionW   = 4;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned SeqLenW  = 5;
  localparam logic [CfgIdxW-1:0] CFG_SEQ_LEN  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_OVERHEAD = 1'b1;
  localparam logic [SeqLenW-1:0] SeqLenRst    = 5'd16;
  localparam logic [ByteW-1:0]   OverheadRst  = 8'd6;

  // Table depth default
  localparam int unsigned TableDepthDef = 16;

  // Commands
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_START = 2'd1;
  localparam logic [CmdW-1:0] CMD_TIMER = 2'd2;

  // Step kinds
  localparam logic [KindW-1:0] KIND_PMIC     = 3'd0;
  localparam logic [KindW-1:0] KIND_GPIO_EN  = 3'd1;
  localparam logic [KindW-1:0] KIND_GPIO_ALT = 3'd2;
  localparam logic [KindW-1:0] KIND_NO_EVENT = 3'd3;
  localparam logic [KindW-1:0] KIND_RTC      = 3'd4;

  // Flag bit positions
  localparam int unsigned FLAG_DOWN_ONLY = 0;
  localparam int unsigned FLAG_UP_ONLY   = 1;
  localparam int unsigned FLAG_DDR       = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_SET_BITS   = 4'd0,
    ACT_CLR_BITS   = 4'd1,
    ACT_PAD_HIGH   = 4'd2,
    ACT_PAD_LOW    = 4'd3,
    ACT_PAD_ALT    = 4'd4,
    ACT_RTC_SET    = 4'd5,
    ACT_RTC_CLR    = 4'd6,
    ACT_TIMER      = 4'd7,
    ACT_POWERED    = 4'd8,
    ACT_DISCHARGED = 4'd9
  } action_e;

  typedef struct packed {
    logic [TicksW-1:0] ticks;
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  target;
    logic [ByteW-1:0]  mask;
    logic [FlagsW-1:0] flags;
  } step_t;

  typedef struct packed {
    logic             valid;
    action_e          action;
    logic [ByteW-1:0] target;
    logic [ByteW-1:0] mask;
  } act_t;

  // Micro-operations driving the datapath
  typedef enum logic [2:0] {
    UOP_IDLE       = 3'd0,
    UOP_READ       = 3'd1,
    UOP_EMIT_A     = 3'd2,
    UOP_EMIT_B     = 3'd3,
    UOP_MOVE       = 3'd4,
    UOP_NOP        = 3'd5,
    UOP_EMIT_TIMER = 3'd6,
    UOP_EMIT_END   = 3'd7
  } uop_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_WALK   = 3'd2,
    COND_OUT_RANGE = 3'd3,
    COND_NO_NEXT   = 3'd4,
    COND_SAME_TICK = 3'd5
  } cond_e;

  // Microprogram addresses
  localparam int unsigned UpcW = 4;
  localparam logic [UpcW-1:0] ADDR_IDLE  = 4'd0;
  localparam logic [UpcW-1:0] ADDR_CHECK = 4'd1;
  localparam logic [UpcW-1:0] ADDR_ACT_A = 4'd2;
  localparam logic [UpcW-1:0] ADDR_ACT_B = 4'd3;
  localparam logic [UpcW-1:0] ADDR_MOVE  = 4'd4;
  localparam logic [UpcW-1:0] ADDR_READ  = 4'd5;
  localparam logic [UpcW-1:0] ADDR_CMP   = 4'd6;
  localparam logic [UpcW-1:0] ADDR_TIMER = 4'd7;
  localparam logic [UpcW-1:0] ADDR_END   = 4'd8;

  typedef struct packed {
    uop_e            uop;
    cond_e           cond;
    logic [UpcW-1:0] jump;
  } uword_t;

  // Control store: jump when the condition holds, else fall through
  function automatic uword_t ucode(input logic [UpcW-1:0] addr);
    uword_t w;
    unique case (addr)
      ADDR_IDLE:  w = '{uop: UOP_IDLE,       cond: COND_NO_WALK,   jump: ADDR_IDLE};
      ADDR_CHECK: w = '{uop: UOP_READ,       cond: COND_OUT_RANGE, jump: ADDR_END};
      ADDR_ACT_A: w = '{uop: UOP_EMIT_A,     cond: COND_NEVER,     jump: ADDR_IDLE};
      ADDR_ACT_B: w = '{uop: UOP_EMIT_B,     cond: COND_NEVER,     jump: ADDR_IDLE};
      ADDR_MOVE:  w = '{uop: UOP_MOVE,       cond: COND_NO_NEXT,   jump: ADDR_END};
      ADDR_READ:  w = '{uop: UOP_READ,       cond: COND_NEVER,     jump: ADDR_IDLE};
      ADDR_CMP:   w = '{uop: UOP_NOP,        cond: COND_SAME_TICK, jump: ADDR_ACT_A};
      ADDR_TIMER: w = '{uop: UOP_EMIT_TIMER, cond: COND_ALWAYS,    jump: ADDR_IDLE};
      ADDR_END:   w = '{uop: UOP_EMIT_END,   cond: COND_ALWAYS,    jump: ADDR_IDLE};
      default:    w = '{uop: UOP_NOP,        cond: COND_ALWAYS,    jump: ADDR_IDLE};
    endcase
    return w;
  endfunction

  // Decode the action of one step; second selects the follow-up action of a gpio alt step
  function automatic act_t step_action(input step_t s, input logic up, input logic ddr,
                                       input logic second);
    act_t a;
    logic skip;
    a.valid  = 1'b0;
    a.action = ACT_SET_BITS;
    a.target = '0;
    a.mask   = '0;
    skip = up ? s.flags[FLAG_DOWN_ONLY] : s.flags[FLAG_UP_ONLY];
    if (second) begin
      if (up && !skip && (s.kind == KIND_GPIO_ALT)) begin
        a.valid  = 1'b1;
        a.action = ACT_PAD_ALT;
        a.target = s.target;
      end
    end else if (!skip) begin
      if (up) begin
        unique case (s.kind)
          KIND_GPIO_EN: begin
            a.valid  = 1'b1;
            a.action = ACT_PAD_HIGH;
            a.target = s.target;
          end
          KIND_GPIO_ALT: begin
            a.valid  = 1'b1;
            a.action = ACT_PAD_LOW;
            a.target = s.target;
          end
          KIND_NO_EVENT: begin
            a.valid = 1'b0;
          end
          KIND_RTC: begin
            a.valid  = 1'b1;
            a.action = ACT_RTC_SET;
            a.mask   = s.mask;
          end
          default: begin
            a.valid  = 1'b1;
            a.action = ACT_SET_BITS;
            a.target = s.target;
            a.mask   = s.mask;
          end
        endcase
      end else begin
        unique case (s.kind)
          KIND_GPIO_EN, KIND_GPIO_ALT: begin
            a.valid  = 1'b1;
            a.action = ACT_PAD_LOW;
            a.target = s.target;
          end
          KIND_NO_EVENT: begin
            a.valid = 1'b0;
          end
          KIND_RTC: begin
            a.valid  = 1'b1;
            a.action = ACT_RTC_CLR;
            a.mask   = s.mask;
          end
          default: begin
            // DDR supplies stay on unless their reset was asked for
            a.valid  = !(s.flags[FLAG_DDR] && !ddr);
            a.action = ACT_CLR_BITS;
            a.target = s.target;
            a.mask   = s.mask;
          end
        endcase
      end
    end
    return a;
  endfunction

endpackage

// ===== design/power_supply_sequencer.sv =====
// Power supply sequencer: a microcoded walk over a table of supply steps.
// A table write or a start/timer command is taken while the sequencer is idle.
// After acceptance the step at the start position is read and its actions are presented; a
// walk that starts outside the table closes at once. Each further step at the same tick is
// read and presented in turn. A done result closes the walk when no next step remains, else
// a timer request does. Input is ready again in the cycle after the closing result is loaded.
// The microprogram and the single table read port set this order, and output stalls hold
// the walk.
// Reset clears control: position 0, direction up, length 16, overhead 6; the table is
// undefined until written.
module power_supply_sequencer import pss_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdW-1:0]      command_i,
  input  logic [EntryIdxW-1:0] entry_index_i,
  input  logic [TicksW-1:0]    entry_ticks_i,
  input  logic [KindW-1:0]     entry_kind_i,
  input  logic [ByteW-1:0]     entry_target_i,
  input  logic [ByteW-1:0]     entry_mask_i,
  input  logic [FlagsW-1:0]    entry_flags_i,
  input  logic [EntryIdxW-1:0] start_position_i,
  input  logic                 use_start_position_i,
  input  logic                 direction_i,
  input  logic                 reset_ddr_supply_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ActionW-1:0]   action_o,
  output logic [ByteW-1:0]     target_o,
  output logic [ByteW-1:0]     mask_o,
  output logic [TicksW-1:0]    delay_ticks_o,
  output logic                 last_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned PosW = (IdxW > EntryIdxW) ? IdxW : EntryIdxW;
  localparam int unsigned LenW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW = ((PosW > LenW) ? PosW : LenW) + 1;
  localparam int unsigned GapW = TicksW + 2;
  localparam logic [CmpW-1:0] DepthC = CmpW'(TableDepth);

  // Control and configuration state
  logic [UpcW-1:0]    upc_q, upc_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               up_q, up_d;
  logic               ddr_q, ddr_d;
  logic [SeqLenW-1:0] seq_len_q;
  logic [ByteW-1:0]   ovh_q;
  logic               out_valid_q, out_valid_d;

  // Datapath payload
  step_t              tbl_q [TableDepth];
  step_t              cur_q;
  logic [TicksW-1:0]  tk_q;
  action_e            out_action_q, out_action_d;
  logic [ByteW-1:0]   out_target_q, out_target_d;
  logic [ByteW-1:0]   out_mask_q, out_mask_d;
  logic [TicksW-1:0]  out_delay_q, out_delay_d;
  logic               out_last_q, out_last_d;

  uword_t             uw;
  act_t               act;
  logic               in_fire, walk_cmd, tbl_we;
  logic [CmpW-1:0]    len, pos_ext, seq_len_ext;
  logic               out_range, no_next, same_tick, take;
  logic               needs_out, out_free, stall, load_out;
  logic [TicksW-1:0]  later, earlier, gap_sat;
  logic signed [GapW-1:0] gap;
  step_t              wr_step;

  // Fetch the control word and decode the current step
  assign uw  = ucode(upc_q);
  assign act = step_action(cur_q, up_q, ddr_q, uw.uop == UOP_EMIT_B);

  assign in_ready_o = (uw.uop == UOP_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign walk_cmd   = (command_i == CMD_START) || (command_i == CMD_TIMER);
  assign tbl_we     = in_fire && (command_i == CMD_WRITE)
                      && (CmpW'(entry_index_i) < DepthC);

  // Clamp the length in use to 1..TableDepth
  assign seq_len_ext = CmpW'(seq_len_q);
  always_comb begin
    priority if (seq_len_q == '0) begin
      len = CmpW'(1);
    end else if (seq_len_ext > DepthC) begin
      len = DepthC;
    end else begin
      len = seq_len_ext;
    end
  end

  // Walk conditions
  assign pos_ext   = CmpW'(pos_q);
  assign out_range = (pos_ext >= len);
  assign no_next   = up_q ? ((pos_ext + CmpW'(1)) >= len) : (pos_q == '0);
  assign same_tick = (cur_q.ticks == tk_q);

  // Timer gap, saturated at zero
  assign later   = up_q ? cur_q.ticks : tk_q;
  assign earlier = up_q ? tk_q : cur_q.ticks;
  assign gap     = $signed({2'b00, later}) - $signed({2'b00, earlier})
                   - $signed(GapW'(ovh_q));
  assign gap_sat = gap[GapW-1] ? '0 : gap[TicksW-1:0];

  // Output slot handshake
  assign out_free = !out_valid_q || out_ready_i;
  always_comb begin
    unique case (uw.uop)
      UOP_EMIT_A, UOP_EMIT_B:        needs_out = act.valid;
      UOP_EMIT_TIMER, UOP_EMIT_END:  needs_out = 1'b1;
      default:                       needs_out = 1'b0;
    endcase
  end
  assign stall    = needs_out && !out_free;
  assign load_out = needs_out && out_free;

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_WALK:   take = !(in_fire && walk_cmd);
      COND_OUT_RANGE: take = out_range;
      COND_NO_NEXT:   take = no_next;
      COND_SAME_TICK: take = same_tick;
      default:        take = 1'b0;
    endcase
  end

  // Sequence the microprogram and update the walk state
  always_comb begin
    upc_d = upc_q;
    pos_d = pos_q;
    up_d  = up_q;
    ddr_d = ddr_q;
    if (!stall) begin
      upc_d = take ? uw.jump : (upc_q + 1'b1);
    end
    unique case (uw.uop)
      UOP_IDLE: begin
        if (in_fire && (command_i == CMD_START)) begin
          if (use_start_position_i) begin
            pos_d = PosW'(start_position_i);
          end
          up_d  = direction_i;
          ddr_d = reset_ddr_supply_i;
        end
      end
      UOP_MOVE: begin
        pos_d = up_q ? (pos_q + 1'b1) : (pos_q - 1'b1);
      end
      UOP_EMIT_END: begin
        if (!stall) begin
          pos_d = up_q ? PosW'(len - CmpW'(1)) : '0;
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  // Select the next result
  always_comb begin
    out_valid_d  = out_valid_q;
    out_action_d = out_action_q;
    out_target_d = out_target_q;
    out_mask_d   = out_mask_q;
    out_delay_d  = out_delay_q;
    out_last_d   = out_last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      unique case (uw.uop)
        UOP_EMIT_TIMER: begin
          out_action_d = ACT_TIMER;
          out_target_d = '0;
          out_mask_d   = '0;
          out_delay_d  = gap_sat;
          out_last_d   = 1'b1;
        end
        UOP_EMIT_END: begin
          out_action_d = up_q ? ACT_POWERED : ACT_DISCHARGED;
          out_target_d = '0;
          out_mask_d   = '0;
          out_delay_d  = '0;
          out_last_d   = 1'b1;
        end
        default: begin
          out_action_d = act.action;
          out_target_d = act.target;
          out_mask_d   = act.mask;
          out_delay_d  = '0;
          out_last_d   = 1'b0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ADDR_IDLE;
      pos_q       <= '0;
      up_q        <= 1'b1;
      ddr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      pos_q       <= pos_d;
      up_q        <= up_d;
      ddr_q       <= ddr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SeqLenRst;
      ovh_q     <= OverheadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEQ_LEN:  seq_len_q <= cfg_data_i[SeqLenW-1:0];
        CFG_OVERHEAD: ovh_q     <= cfg_data_i;
        default:      ovh_q     <= ovh_q;
      endcase
    end
  end

  // Step table
  assign wr_step = '{ticks: entry_ticks_i, kind: entry_kind_i, target: entry_target_i,
                     mask: entry_mask_i, flags: entry_flags_i};
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[IdxW'(entry_index_i)] <= wr_step;
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    if (uw.uop == UOP_READ) begin
      cur_q <= tbl_q[pos_q[IdxW-1:0]];
    end
    if (uw.uop == UOP_MOVE) begin
      tk_q <= cur_q.ticks;
    end
    out_action_q <= out_action_d;
    out_target_q <= out_target_d;
    out_mask_q   <= out_mask_d;
    out_delay_q  <= out_delay_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign target_o      = out_target_q;
  assign mask_o        = out_mask_q;
  assign delay_ticks_o = out_delay_q;
  assign last_o        = out_last_q;

  // A finished walk leaves the position inside the table in use
  a_end_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == ADDR_IDLE && $past(upc_q) == ADDR_END) |-> (pos_ext < len))
    else $error("position outside table after walk end");

  // The closing result is loaded with last set and control returns to idle
  a_final_loads_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (uw.uop == UOP_EMIT_TIMER || uw.uop == UOP_EMIT_END))
    |=> (out_valid_o && last_o && upc_q == ADDR_IDLE))
    else $error("closing result not marked last");

  // Only a timer or a done result closes a transaction
  a_last_is_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      (action_o == ACT_TIMER || action_o == ACT_POWERED || action_o == ACT_DISCHARGED))
    else $error("last set on a step action");

  // Delay is zero except on a timer request
  a_delay_only_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o != ACT_TIMER) |-> (delay_ticks_o == '0))
    else $error("nonzero delay on a non-timer action");

endmodule
